// ===== rtl/id3ca_pkg.sv =====
// ----------------------------------------------------------------------------
// id3ca_pkg: shared types and constants of the cover-art extractor
// Status codes, image type codes, the tag and frame identifier characters,
// the MIME strings that are recognised and the result word passed from the
// parser to the output register.
// ----------------------------------------------------------------------------
package id3ca_pkg;

  localparam int DATA_W = 8;
  localparam int IMG_W  = 3;
  localparam int STAT_W = 2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_IMAGE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_TAG   = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_FRAME = 2'd2;

  // Image type codes.
  localparam logic [IMG_W-1:0] IMG_UNKNOWN = 3'd0;
  localparam logic [IMG_W-1:0] IMG_BMP     = 3'd1;
  localparam logic [IMG_W-1:0] IMG_GIF     = 3'd2;
  localparam logic [IMG_W-1:0] IMG_PNG     = 3'd3;
  localparam logic [IMG_W-1:0] IMG_JPEG    = 3'd4;

  // Tag magic, supported major versions and the frame identifier.
  localparam logic [DATA_W-1:0] CH_I  = 8'h49;
  localparam logic [DATA_W-1:0] CH_D  = 8'h44;
  localparam logic [DATA_W-1:0] CH_3  = 8'h33;
  localparam logic [DATA_W-1:0] VER_3 = 8'h03;
  localparam logic [DATA_W-1:0] VER_4 = 8'h04;
  localparam logic [DATA_W-1:0] CH_C  = 8'h43;
  localparam logic [23:0]       APIC_HEAD = {8'h41, 8'h50, 8'h49};

  // MIME strings; the first character sits in the top byte.
  localparam int MIME_SHORT_LEN = 9;
  localparam int MIME_LONG_LEN  = 10;
  localparam logic [8*MIME_SHORT_LEN-1:0] MIME_BMP  = "image/bmp";
  localparam logic [8*MIME_SHORT_LEN-1:0] MIME_GIF  = "image/gif";
  localparam logic [8*MIME_SHORT_LEN-1:0] MIME_PNG  = "image/png";
  localparam logic [8*MIME_SHORT_LEN-1:0] MIME_JPG  = "image/jpg";
  localparam logic [8*MIME_LONG_LEN-1:0]  MIME_JPEG = "image/jpeg";

  // One result word from the parser.
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data;
    logic [IMG_W-1:0]  img_type;
    logic              last;
    logic [STAT_W-1:0] status;
  } res_t;

endpackage

// ===== rtl/id3ca_mime_class.sv =====
// ----------------------------------------------------------------------------
// id3ca_mime_class: MIME string classifier
// Compares the captured MIME characters and length with the recognised
// image MIME strings and gives the image type code.
// ----------------------------------------------------------------------------
module id3ca_mime_class
  import id3ca_pkg::*;
#(
  parameter int MIME_MAX = 10,
  localparam int LEN_W = $clog2(MIME_MAX + 2)
) (
  input  logic [DATA_W-1:0] mime_chars [MIME_MAX],
  input  logic [LEN_W-1:0]  char_count,
  output logic [IMG_W-1:0]  img_type
);

  logic [8*MIME_LONG_LEN-1:0]  head;
  logic [8*MIME_SHORT_LEN-1:0] head_short;
  logic                        len_short;
  logic                        len_long;

  always_comb begin
    for (int i = 0; i < MIME_LONG_LEN; i++) begin
      head[8*(MIME_LONG_LEN-1-i) +: 8] = mime_chars[i];
    end
  end

  assign head_short = head[8*MIME_LONG_LEN-1 -: 8*MIME_SHORT_LEN];
  assign len_short  = (char_count == LEN_W'(MIME_SHORT_LEN));
  assign len_long   = (char_count == LEN_W'(MIME_LONG_LEN));

  always_comb begin
    priority if (len_short && head_short == MIME_BMP) begin
      img_type = IMG_BMP;
    end else if (len_short && head_short == MIME_GIF) begin
      img_type = IMG_GIF;
    end else if (len_short && head_short == MIME_PNG) begin
      img_type = IMG_PNG;
    end else if ((len_short && head_short == MIME_JPG) || (len_long && head == MIME_JPEG)) begin
      img_type = IMG_JPEG;
    end else begin
      img_type = IMG_UNKNOWN;
    end
  end

endmodule

// ===== rtl/id3ca_parser.sv =====
// ----------------------------------------------------------------------------
// id3ca_parser: per-byte tag and frame parser
// Holds the parse state and works out, for one file byte, the next state
// and the result word that the byte causes, if any.
// ----------------------------------------------------------------------------
module id3ca_parser
  import id3ca_pkg::*;
#(
  parameter int MIME_MAX = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [DATA_W-1:0] data_byte,
  input  logic              data_eof,
  output res_t              res
);

  localparam int LEN_W = $clog2(MIME_MAX + 2);
  localparam int IDX_W = $clog2(MIME_MAX);

  localparam logic [3:0] PH_HDR    = 4'd0;
  localparam logic [3:0] PH_SEARCH = 4'd1;
  localparam logic [3:0] PH_FSIZE  = 4'd2;
  localparam logic [3:0] PH_FLAGS  = 4'd3;
  localparam logic [3:0] PH_ENC    = 4'd4;
  localparam logic [3:0] PH_MIME   = 4'd5;
  localparam logic [3:0] PH_PTYPE  = 4'd6;
  localparam logic [3:0] PH_DESC   = 4'd7;
  localparam logic [3:0] PH_ZEROS  = 4'd8;
  localparam logic [3:0] PH_IMAGE  = 4'd9;
  localparam logic [3:0] PH_DONE   = 4'd10;

  logic [3:0]        phase_r, phase_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic [27:0]       tag_r, tag_nxt;
  logic              v4_r, v4_nxt;
  logic [23:0]       win_r, win_nxt;
  logic [31:0]       frame_r, frame_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [IMG_W-1:0]  kind_r, kind_nxt;
  logic [DATA_W-1:0] mime_r [MIME_MAX];
  logic              mime_we;

  logic [IMG_W-1:0]  mime_kind;
  logic              hdr_bad;
  logic [27:0]       tag_shift;
  logic              tag_zero;
  logic              tag_left_zero;
  logic              frame_zero;
  logic              frame_left_zero;
  logic              img_last;

  id3ca_mime_class #(
    .MIME_MAX (MIME_MAX)
  ) u_mime_class (
    .mime_chars (mime_r),
    .char_count (len_r),
    .img_type   (mime_kind)
  );

  assign hdr_bad = (cnt_r == 4'd0 && data_byte != CH_I) ||
                   (cnt_r == 4'd1 && data_byte != CH_D) ||
                   (cnt_r == 4'd2 && data_byte != CH_3) ||
                   (cnt_r == 4'd3 && data_byte != VER_3 && data_byte != VER_4);

  // Synchsafe bytes contribute their low seven bits.
  assign tag_shift = {tag_r[20:0], data_byte[6:0]};

  // Zero tests of the counters, before and after their guarded decrement.
  assign tag_zero        = (tag_r == 28'd0);
  assign tag_left_zero   = tag_zero || (tag_r == 28'd1);
  assign frame_zero      = (frame_r == 32'd0);
  assign frame_left_zero = frame_zero || (frame_r == 32'd1);
  assign img_last        = frame_left_zero || data_eof;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    tag_nxt   = tag_r;
    v4_nxt    = v4_r;
    win_nxt   = win_r;
    frame_nxt = frame_r;
    len_nxt   = len_r;
    kind_nxt  = kind_r;
    mime_we   = 1'b0;
    res       = '0;

    unique case (phase_r)
      PH_HDR: begin
        if (hdr_bad) begin
          res.valid  = 1'b1;
          res.last   = 1'b1;
          res.status = ST_NO_TAG;
          phase_nxt  = PH_DONE;
        end else begin
          if (cnt_r == 4'd3) begin
            v4_nxt = (data_byte == VER_4);
          end
          if (cnt_r >= 4'd6) begin
            tag_nxt = tag_shift;
          end
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_r >= 4'd9) begin
            phase_nxt = PH_SEARCH;
            cnt_nxt   = 4'd0;
            win_nxt   = 24'd0;
            if (tag_shift == 28'd0) begin
              res.valid  = 1'b1;
              res.last   = 1'b1;
              res.status = ST_NO_FRAME;
              phase_nxt  = PH_DONE;
            end
          end
        end
      end
      PH_SEARCH: begin
        if (!tag_zero) begin
          tag_nxt = tag_r - 28'd1;
        end
        if (win_r == APIC_HEAD && data_byte == CH_C) begin
          phase_nxt = PH_FSIZE;
          cnt_nxt   = 4'd0;
          frame_nxt = 32'd0;
        end else if (tag_left_zero) begin
          res.valid  = 1'b1;
          res.last   = 1'b1;
          res.status = ST_NO_FRAME;
          phase_nxt  = PH_DONE;
        end
        win_nxt = {win_r[15:0], data_byte};
      end
      PH_FSIZE: begin
        frame_nxt = v4_r ? {frame_r[24:0], data_byte[6:0]} : {frame_r[23:0], data_byte};
        if (cnt_r == 4'd3) begin
          phase_nxt = PH_FLAGS;
          cnt_nxt   = 4'd0;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      PH_FLAGS: begin
        if (cnt_r == 4'd1) begin
          phase_nxt = PH_ENC;
          cnt_nxt   = 4'd0;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      PH_ENC, PH_MIME, PH_PTYPE, PH_DESC, PH_ZEROS: begin
        if (frame_zero) begin
          res.valid  = 1'b1;
          res.last   = 1'b1;
          res.status = ST_NO_FRAME;
          phase_nxt  = PH_DONE;
        end else begin
          frame_nxt = frame_r - 32'd1;
          unique case (phase_r)
            PH_ENC: begin
              phase_nxt = PH_MIME;
              len_nxt   = '0;
            end
            PH_MIME: begin
              if (data_byte == 8'd0) begin
                kind_nxt  = mime_kind;
                phase_nxt = PH_PTYPE;
              end else begin
                mime_we = (len_r < LEN_W'(MIME_MAX));
                if (len_r <= LEN_W'(MIME_MAX)) begin
                  len_nxt = len_r + LEN_W'(1);
                end
              end
            end
            PH_PTYPE: begin
              phase_nxt = PH_DESC;
            end
            PH_DESC: begin
              if (data_byte == 8'd0) begin
                phase_nxt = PH_ZEROS;
              end
            end
            default: begin
              if (data_byte != 8'd0) begin
                res.valid    = 1'b1;
                res.data     = data_byte;
                res.img_type = kind_r;
                res.last     = img_last;
                res.status   = ST_IMAGE;
                phase_nxt    = img_last ? PH_DONE : PH_IMAGE;
              end
            end
          endcase
          if (!res.valid && frame_left_zero) begin
            res.valid  = 1'b1;
            res.last   = 1'b1;
            res.status = ST_NO_FRAME;
            phase_nxt  = PH_DONE;
          end
        end
      end
      PH_IMAGE: begin
        if (!frame_zero) begin
          frame_nxt = frame_r - 32'd1;
        end
        res.valid    = 1'b1;
        res.data     = data_byte;
        res.img_type = kind_r;
        res.last     = img_last;
        res.status   = ST_IMAGE;
        if (img_last) begin
          phase_nxt = PH_DONE;
        end
      end
      default: begin
      end
    endcase

    // The final byte of a file closes with an error word any parse that is not
    // done and gave no word for that byte, and returns everything to the start-of-file state.
    if (data_eof) begin
      if (!res.valid && phase_nxt != PH_DONE) begin
        res.valid  = 1'b1;
        res.last   = 1'b1;
        res.status = (phase_nxt == PH_HDR) ? ST_NO_TAG : ST_NO_FRAME;
      end
      phase_nxt = PH_HDR;
      cnt_nxt   = 4'd0;
      tag_nxt   = 28'd0;
      v4_nxt    = 1'b0;
      win_nxt   = 24'd0;
      frame_nxt = 32'd0;
      len_nxt   = '0;
      kind_nxt  = IMG_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR;
      cnt_r   <= 4'd0;
      tag_r   <= 28'd0;
      v4_r    <= 1'b0;
      win_r   <= 24'd0;
      frame_r <= 32'd0;
      len_r   <= '0;
      kind_r  <= IMG_UNKNOWN;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      tag_r   <= tag_nxt;
      v4_r    <= v4_nxt;
      win_r   <= win_nxt;
      frame_r <= frame_nxt;
      len_r   <= len_nxt;
      kind_r  <= kind_nxt;
    end
  end

  // Only characters below the current length are ever compared, so the
  // character store needs no reset.
  always_ff @(posedge clk) begin
    if (step && mime_we) begin
      mime_r[len_r[IDX_W-1:0]] <= data_byte;
    end
  end

endmodule

// ===== rtl/id3v2_cover_art_extractor.sv =====
// ----------------------------------------------------------------------------
// id3v2_cover_art_extractor: cover picture extractor for tagged audio files
// Streams a file from its first byte and returns the embedded picture bytes.
// ----------------------------------------------------------------------------
// The block takes one file byte per word on the in_ channel and returns the
// picture bytes of the first attached-picture frame on the out_ channel, one
// byte per word, each tagged with the image type taken from the MIME string
// and with is_last on the final picture byte. A missing tag or unsupported
// version gives a single status 1 word, and a tag without a usable picture
// frame a single status 2 word; both carry is_last and a zero byte. Every
// word that carries end_of_file ends the file, and the next byte is taken as
// the start of a new one. The block accepts one byte in every cycle while
// the out_ side does not stall: a byte is captured in an input register, and
// once the output register is free or is being emptied, the parser updates
// its state from that byte and loads any result into the output register at
// the same clock edge, from which the result is presented on the out_ ports.
// The input register, the single parser stage and the output register set
// this rate; a stall on the out_ side holds the output register and, once the
// input register is also full, raises in_stall.
module id3v2_cover_art_extractor
  import id3ca_pkg::*;
#(
  parameter int MIME_MAX = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [DATA_W-1:0] in_byte,
  input  logic              in_end_of_file,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_byte,
  output logic [IMG_W-1:0]  out_image_type,
  output logic              out_is_last,
  output logic [STAT_W-1:0] out_status
);

  logic              s1_valid_r;
  logic [DATA_W-1:0] s1_byte_r;
  logic              s1_eof_r;
  logic              in_take;
  logic              advance;
  res_t              res;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_byte_r;
  logic [IMG_W-1:0]  out_type_r;
  logic              out_last_r;
  logic [STAT_W-1:0] out_status_r;

  // The held byte moves on whenever the output register is free or is being
  // emptied in this cycle.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_byte;
      s1_eof_r  <= in_end_of_file;
    end
  end

  id3ca_parser #(
    .MIME_MAX (MIME_MAX)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data_byte (s1_byte_r),
    .data_eof  (s1_eof_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_byte_r   <= res.data;
      out_type_r   <= res.img_type;
      out_last_r   <= res.last;
      out_status_r <= res.status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_image_type = out_type_r;
  assign out_is_last    = out_last_r;
  assign out_status     = out_status_r;

endmodule

// ===== rtl/id3ca_checker.sv =====
// ----------------------------------------------------------------------------
// id3ca_checker: port-level checks of the cover-art extractor
// Watches the top-level ports and flags results that break the block's
// output rules; bound to the top level below.
// ----------------------------------------------------------------------------
module id3ca_checker
  import id3ca_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [DATA_W-1:0] out_byte,
  input logic [IMG_W-1:0]  out_image_type,
  input logic              out_is_last,
  input logic [STAT_W-1:0] out_status
);

  logic             in_pic_r;
  logic [IMG_W-1:0] pic_type_r;
  logic             out_take;

  assign out_take = out_valid && !out_stall;

  // Set while a picture has started and its last byte has not been taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_pic_r <= 1'b0;
    end else if (out_take) begin
      in_pic_r <= (out_status == ST_IMAGE) && !out_is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      pic_type_r <= out_image_type;
    end
  end

  // The input side only backs up behind a blocked result.
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall raised while the result side is free");

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_byte) && $stable(out_status)))
    else $error("stalled result word changed");

  a_error_form : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_IMAGE) |->
      (out_is_last && out_byte == 8'd0 && out_image_type == IMG_UNKNOWN))
    else $error("error result is not a closing zero word");

  // Once a picture has begun, every further word is a picture byte of the
  // same type until the one marked last.
  a_pic_run : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && in_pic_r) |-> (out_status == ST_IMAGE && out_image_type == pic_type_r))
    else $error("picture run broken before its last byte");

endmodule

bind id3v2_cover_art_extractor id3ca_checker u_id3ca_checker (.*);
